// File: rtl/crm_pkg.sv
`default_nettype none

package crm_pkg;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_LOCKOUT     = 3'd0,
    REG_MAX_CPM     = 3'd1,
    REG_IDLE        = 3'd2,
    REG_WINDOW      = 3'd3,
    REG_CUT_LAMP    = 3'd4,
    REG_SECOND_LAMP = 3'd5
  } crm_reg_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEC,
    S_DIV,
    S_FIN,
    S_OUT
  } crm_state_e;

  localparam int APB_ADDR_W = 5;
  localparam int APB_DATA_W = 32;

  localparam int CFG_W    = 16;
  localparam int WINDOW_W = 20;
  localparam int RATE_W   = 16;
  localparam int COUNT_W  = 16;
  localparam int SEC_W    = 11;

  localparam logic [CFG_W-1:0]    LOCKOUT_RST     = 16'd300;
  localparam logic [CFG_W-1:0]    MAX_CPM_RST     = 16'd300;
  localparam logic [CFG_W-1:0]    IDLE_RST        = 16'd3000;
  localparam logic [WINDOW_W-1:0] WINDOW_RST      = 20'd60000;
  localparam logic [CFG_W-1:0]    CUT_LAMP_RST    = 16'd150;
  localparam logic [CFG_W-1:0]    SECOND_LAMP_RST = 16'd300;

  localparam logic [RATE_W-1:0] RATE_NUMER   = 16'd60000;
  localparam logic [CFG_W-1:0]  SECOND_MS    = 16'd1000;
  localparam logic [SEC_W-1:0]  IDLE_SECONDS = 11'd60;

  // divider: numerator up to 2*60000-1, divisor up to 60000
  localparam int DIV_NUM_W = 17;
  localparam int DIV_DEN_W = 16;
  localparam int DIV_CNT_W = $clog2(DIV_NUM_W);

  // ms to seconds: floor(x / 1000) = (x * SEC_RECIP) >> SEC_SHIFT, exact for x < 2**20
  localparam int                 SEC_RECIP_W = 21;
  localparam int                 SEC_SHIFT   = 30;
  localparam logic [SEC_RECIP_W-1:0] SEC_RECIP = 21'd1073742;

  typedef struct packed {
    logic                 start;
    logic [DIV_NUM_W-1:0] num;
    logic [DIV_DEN_W-1:0] den;
  } crm_div_req_t;

  typedef struct packed {
    logic              done;
    logic [RATE_W-1:0] quo;
  } crm_div_sts_t;

endpackage

`default_nettype wire

// File: rtl/crm_in_if.sv
`default_nettype none

interface crm_in_if;
  logic valid;
  logic ready;
  logic edge_seen;

  modport source (output valid, output edge_seen, input ready);
  modport sink   (input valid, input edge_seen, output ready);
endinterface

`default_nettype wire

// File: rtl/crm_out_if.sv
`default_nettype none

interface crm_out_if
  import crm_pkg::*;
();
  logic                valid;
  logic                ready;
  logic                cut_accepted;
  logic [RATE_W-1:0]   rate_now;
  logic [RATE_W-1:0]   rate_shown;
  logic [COUNT_W-1:0]  count_shown;
  logic [SEC_W-1:0]    seconds_shown;
  logic                running;
  logic                cut_lamp;
  logic                second_lamp;

  modport source (
    output valid, output cut_accepted, output rate_now, output rate_shown,
    output count_shown, output seconds_shown, output running, output cut_lamp,
    output second_lamp, input ready
  );
  modport sink (
    input valid, input cut_accepted, input rate_now, input rate_shown,
    input count_shown, input seconds_shown, input running, input cut_lamp,
    input second_lamp, output ready
  );
endinterface

`default_nettype wire

// File: rtl/crm_div.sv
`default_nettype none

// restoring divider, one quotient bit per cycle
module crm_div
  import crm_pkg::*;
(
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire crm_div_req_t req_i,
  output crm_div_sts_t      sts_o
);

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [DIV_DEN_W-1:0] rem_q, rem_d;
  logic [DIV_NUM_W-1:0] quo_q, quo_d;
  logic [DIV_DEN_W-1:0] den_q, den_d;
  logic [DIV_DEN_W:0]   trial;
  logic [DIV_DEN_W:0]   diff;
  logic                 fits;

  assign trial = {rem_q, quo_q[DIV_NUM_W-1]};
  assign diff  = trial - {1'b0, den_q};
  assign fits  = trial >= {1'b0, den_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    den_d  = den_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = DIV_CNT_W'(DIV_NUM_W - 1);
      rem_d  = '0;
      quo_d  = req_i.num;
      den_d  = req_i.den;
    end else if (busy_q) begin
      rem_d = fits ? diff[DIV_DEN_W-1:0] : trial[DIV_DEN_W-1:0];
      quo_d = {quo_q[DIV_NUM_W-2:0], fits};
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q - DIV_CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    den_q <= den_d;
  end

  assign sts_o.done = done_q;
  assign sts_o.quo  = quo_q[RATE_W-1:0];

endmodule

`default_nettype wire

// File: rtl/cut_rate_meter_core.sv
`default_nettype none

// channel   dir  payload                                         request taken when
// in_i      in   edge_seen                                       valid & ready
// out_o     out  cut_accepted rate_now rate_shown count_shown    valid & ready
//                seconds_shown running cut_lamp second_lamp
// apb       in   six config registers at 4*index                 psel & penable & pwrite
//
// one request at a time: ready is low from acceptance until its result is taken
// tick without a cut: after acceptance the sequencer passes S_SEC and S_FIN, then offers out valid in S_OUT
// tick with a cut below 60001 ms period: S_DIV is added, waiting for the 17-step divider
// the seconds value is one registered 20x21 multiply in the cycle after acceptance
// reset (async, active low) loads the register defaults and clears all timers
// a stalled result holds in the output register and blocks the next request

module cut_rate_meter_core
  import crm_pkg::*;
#(
  parameter int TIME_WIDTH = 32
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  crm_in_if.sink                     in_i,
  crm_out_if.source                  out_o,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [APB_ADDR_W-1:0] paddr,
  input  wire logic [APB_DATA_W-1:0] pwdata,
  output logic      [APB_DATA_W-1:0] prdata,
  output logic                       pready
);

  localparam int TW = TIME_WIDTH;
  localparam int CW = (TIME_WIDTH > WINDOW_W) ? TIME_WIDTH : WINDOW_W;

  // configuration
  logic [CFG_W-1:0]    lockout_q, max_cpm_q, idle_q, cut_lamp_ms_q, sec_lamp_ms_q;
  logic [WINDOW_W-1:0] window_q;
  crm_reg_e            reg_idx;

  // tick state
  logic [TW-1:0]      s_acc_q, s_cut_q, s_act_q, s_win_q, s_cl_q, s_sl_q;
  logic [TW-1:0]      s_acc_d, s_cut_d, s_act_d, s_win_d, s_cl_d, s_sl_d;
  logic [COUNT_W-1:0] wcount_q, wcount_d;
  logic               active_q, active_d;
  logic [RATE_W-1:0]  rate_hold_q;
  logic [COUNT_W-1:0] count_hold_q, count_hold_d;
  logic [SEC_W-1:0]   sec_hold_q, sec_hold_d;

  // per-request working registers
  crm_state_e          state_q, state_d;
  logic                cut_q, big_q, clear_q, sec_upd_q;
  logic [WINDOW_W-1:0] sec_num_q;
  logic [RATE_W-1:0]   per_q;
  logic [RATE_W-1:0]   rate_q;

  logic cut, big, timeout, sec_upd;
  logic [CW-1:0] win_ext, s_win_ext;
  logic [TW-1:0] sa, sc;
  logic in_acc, out_acc;

  logic in_ready, out_valid, div_start, sec_load, rate_load, fin;
  logic [WINDOW_W+SEC_RECIP_W-1:0] sec_prod;
  logic [RATE_W-1:0] rate_hold_fin;

  crm_div_req_t div_req;
  crm_div_sts_t div_sts;

  function automatic logic [TIME_WIDTH-1:0] tick_up(input logic [TIME_WIDTH-1:0] v);
    return (&v) ? v : v + TIME_WIDTH'(1);
  endfunction

  // apb register file
  assign pready  = 1'b1;
  assign reg_idx = crm_reg_e'(paddr[APB_ADDR_W-1:2]);

  always_comb begin
    case (reg_idx)
      REG_LOCKOUT:     prdata = APB_DATA_W'(lockout_q);
      REG_MAX_CPM:     prdata = APB_DATA_W'(max_cpm_q);
      REG_IDLE:        prdata = APB_DATA_W'(idle_q);
      REG_WINDOW:      prdata = APB_DATA_W'(window_q);
      REG_CUT_LAMP:    prdata = APB_DATA_W'(cut_lamp_ms_q);
      REG_SECOND_LAMP: prdata = APB_DATA_W'(sec_lamp_ms_q);
      default:         prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lockout_q     <= LOCKOUT_RST;
      max_cpm_q     <= MAX_CPM_RST;
      idle_q        <= IDLE_RST;
      window_q      <= WINDOW_RST;
      cut_lamp_ms_q <= CUT_LAMP_RST;
      sec_lamp_ms_q <= SECOND_LAMP_RST;
    end else if (psel && penable && pwrite && pready) begin
      case (reg_idx)
        REG_LOCKOUT:     lockout_q     <= pwdata[CFG_W-1:0];
        REG_MAX_CPM:     max_cpm_q     <= pwdata[CFG_W-1:0];
        REG_IDLE:        idle_q        <= pwdata[CFG_W-1:0];
        REG_WINDOW:      window_q      <= pwdata[WINDOW_W-1:0];
        REG_CUT_LAMP:    cut_lamp_ms_q <= pwdata[CFG_W-1:0];
        REG_SECOND_LAMP: sec_lamp_ms_q <= pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  // one millisecond tick, all counters advance before the edge is looked at
  assign win_ext   = CW'(window_q);
  assign s_win_ext = CW'(s_win_d);

  always_comb begin
    sa       = tick_up(s_acc_q);
    sc       = tick_up(s_cut_q);
    s_acc_d  = sa;
    s_cut_d  = sc;
    s_act_d  = tick_up(s_act_q);
    s_win_d  = tick_up(s_win_q);
    s_cl_d   = tick_up(s_cl_q);
    s_sl_d   = tick_up(s_sl_q);
    wcount_d = wcount_q;
    active_d = active_q;
    count_hold_d = count_hold_q;
    sec_hold_d   = sec_hold_q;
    timeout  = 1'b0;
    sec_upd  = 1'b0;

    cut = in_i.edge_seen && (sa > TW'(lockout_q));
    big = sc > TW'(RATE_NUMER);

    if (cut) begin
      s_acc_d  = '0;
      s_cut_d  = '0;
      s_act_d  = '0;
      s_cl_d   = '0;
      active_d = 1'b1;
      if (wcount_q != '1) begin
        wcount_d = wcount_q + COUNT_W'(1);
      end
      count_hold_d = wcount_d;
    end

    if (active_d && (s_act_d >= TW'(idle_q))) begin
      timeout      = 1'b1;
      active_d     = 1'b0;
      count_hold_d = '0;
      sec_hold_d   = IDLE_SECONDS;
    end

    if (active_d && (CW'(s_win_d) <= win_ext)) begin
      if (s_sl_d >= TW'(SECOND_MS)) begin
        s_sl_d  = '0;
        sec_upd = 1'b1;
      end
    end else begin
      wcount_d = '0;
      s_win_d  = '0;
    end
  end

  assign in_acc  = in_i.valid && in_i.ready;
  assign out_acc = out_o.valid && out_o.ready;

  // sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (in_acc) state_d = S_SEC;
      S_SEC:  state_d = (cut_q && !big_q) ? S_DIV : S_FIN;
      S_DIV:  if (div_sts.done) state_d = S_FIN;
      S_FIN:  state_d = S_OUT;
      S_OUT:  if (out_acc) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    out_valid = 1'b0;
    div_start = 1'b0;
    sec_load  = 1'b0;
    rate_load = 1'b0;
    fin       = 1'b0;
    unique case (state_q)
      S_IDLE: in_ready = 1'b1;
      S_SEC: begin
        div_start = cut_q && !big_q;
        sec_load  = sec_upd_q;
      end
      S_DIV:  rate_load = div_sts.done;
      S_FIN:  fin = 1'b1;
      S_OUT:  out_valid = 1'b1;
      default: ;
    endcase
  end

  assign in_i.ready = in_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // divider: ceil(60000 / p) = (60000 + p - 1) / p
  assign div_req.start = div_start;
  assign div_req.num   = {1'b0, RATE_NUMER} + {1'b0, per_q} - DIV_NUM_W'(1);
  assign div_req.den   = per_q;

  crm_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .sts_o  (div_sts)
  );

  assign sec_prod = sec_num_q * SEC_RECIP;

  assign rate_hold_fin = (cut_q && !clear_q && (rate_q < max_cpm_q)) ? rate_q : rate_hold_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_acc_q      <= '0;
      s_cut_q      <= '0;
      s_act_q      <= '0;
      s_win_q      <= '0;
      s_cl_q       <= '0;
      s_sl_q       <= '0;
      wcount_q     <= '0;
      active_q     <= 1'b0;
      rate_hold_q  <= '0;
      count_hold_q <= '0;
      sec_hold_q   <= '0;
    end else begin
      if (in_acc) begin
        s_acc_q      <= s_acc_d;
        s_cut_q      <= s_cut_d;
        s_act_q      <= s_act_d;
        s_win_q      <= s_win_d;
        s_cl_q       <= s_cl_d;
        s_sl_q       <= s_sl_d;
        wcount_q     <= wcount_d;
        active_q     <= active_d;
        count_hold_q <= count_hold_d;
        sec_hold_q   <= sec_hold_d;
        if (timeout) begin
          rate_hold_q <= '0;
        end
      end
      if (sec_load) begin
        sec_hold_q <= sec_prod[SEC_SHIFT+SEC_W-1:SEC_SHIFT];
      end
      if (fin) begin
        rate_hold_q <= rate_hold_fin;
      end
    end
  end

  // working registers, payload only
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      cut_q     <= cut;
      big_q     <= big;
      clear_q   <= timeout;
      sec_upd_q <= sec_upd;
      sec_num_q <= s_win_ext[WINDOW_W-1:0];
      per_q     <= sc[RATE_W-1:0];
      rate_q    <= (cut && big) ? RATE_W'(1) : '0;
    end else if (rate_load) begin
      rate_q <= div_sts.quo;
    end
  end

  // output register
  logic               o_cut_q, o_run_q, o_cl_q, o_sl_q;
  logic [RATE_W-1:0]  o_rate_q, o_shown_q;
  logic [COUNT_W-1:0] o_count_q;
  logic [SEC_W-1:0]   o_sec_q;

  always_ff @(posedge clk_i) begin
    if (fin) begin
      o_cut_q   <= cut_q;
      o_rate_q  <= rate_q;
      o_shown_q <= rate_hold_fin;
      o_count_q <= count_hold_q;
      o_sec_q   <= sec_hold_q;
      o_run_q   <= active_q;
      o_cl_q    <= s_cl_q < TW'(cut_lamp_ms_q);
      o_sl_q    <= s_sl_q < TW'(sec_lamp_ms_q);
    end
  end

  assign out_o.valid         = out_valid;
  assign out_o.cut_accepted  = o_cut_q;
  assign out_o.rate_now      = o_rate_q;
  assign out_o.rate_shown    = o_shown_q;
  assign out_o.count_shown   = o_count_q;
  assign out_o.seconds_shown = o_sec_q;
  assign out_o.running       = o_run_q;
  assign out_o.cut_lamp      = o_cl_q;
  assign out_o.second_lamp   = o_sl_q;

endmodule

`default_nettype wire

// File: rtl/crm_checker.sv
`default_nettype none

module crm_checker
  import crm_pkg::*;
(
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               in_valid_i,
  input wire logic               in_ready_i,
  input wire logic               out_valid_i,
  input wire logic               out_ready_i,
  input wire logic               cut_accepted_i,
  input wire logic [RATE_W-1:0]  rate_now_i,
  input wire logic [RATE_W-1:0]  rate_shown_i,
  input wire logic [COUNT_W-1:0] count_shown_i,
  input wire logic               running_i
);

  // one request in flight: never ready while a result is offered
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_i && out_valid_i))
    else $error("input ready while a result is pending");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i) |=> !in_ready_i)
    else $error("ready did not drop after a request");

  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> (out_valid_i && $stable(rate_now_i)))
    else $error("stalled result changed");

  // a cut always has a nonzero rate, no cut reports zero
  a_rate_with_cut: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (cut_accepted_i == (rate_now_i != '0)))
    else $error("rate_now disagrees with cut_accepted");

  a_idle_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !running_i) |-> (rate_shown_i == '0 && count_shown_i == '0))
    else $error("displays not cleared while stopped");

endmodule

bind cut_rate_meter_core crm_checker u_crm_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_i.valid),
  .in_ready_i     (in_i.ready),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .cut_accepted_i (out_o.cut_accepted),
  .rate_now_i     (out_o.rate_now),
  .rate_shown_i   (out_o.rate_shown),
  .count_shown_i  (out_o.count_shown),
  .running_i      (out_o.running)
);

`default_nettype wire
